### src/text_terminal_with_color_escapes_defines.svh
// assertion macros used by the terminal datapath
`ifndef TEXT_TERMINAL_WITH_COLOR_ESCAPES_DEFINES_SVH
`define TEXT_TERMINAL_WITH_COLOR_ESCAPES_DEFINES_SVH
`ifndef SYNTHESIS
`define TTC_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ttc assertion failed");
`define TTC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ttc assertion failed");
`else
`define TTC_ASSERT(lbl, expr)
`define TTC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### src/ttc_pkg.sv
// shared types, constants and tables of the text terminal
package ttc_pkg;

    localparam int COLS   = 80;
    localparam int LINES  = 25;
    localparam int CELLS  = COLS * LINES;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    localparam logic [7:0] ATTR_DEFAULT = 8'h07;
    localparam logic [7:0] MASK_FG_KEEP = 8'h8F;
    localparam logic [7:0] MASK_BG_KEEP = 8'hF8;
    localparam logic [7:0] BIT_BRIGHT   = 8'h08;
    localparam logic [7:0] BIT_FLASH    = 8'h80;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BSL       = 8'h5C;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_LBR       = 8'h5B;
    localparam logic [7:0] CH_M         = 8'h6D;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_MOVE  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_GLYPH,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_CLR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic glyph;
        logic scr_rd;
        logic scr_wr;
        logic clr;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic exec_glyph;
        logic exec_scroll;
        logic glyph_more;
        logic glyph_scroll;
        logic glyph_left;
        logic sweep_last;
        logic out_free;
    } dp_sts_t;

    function automatic logic [2:0] iso_to_vga(input logic [2:0] c);
        logic [2:0] r;
        case (c)
            3'd0: r = 3'd0;
            3'd1: r = 3'd4;
            3'd2: r = 3'd2;
            3'd3: r = 3'd6;
            3'd4: r = 3'd1;
            3'd5: r = 3'd5;
            3'd6: r = 3'd3;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] lead_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0: r = CH_BSL;
            2'd1: r = CH_E;
            default: r = CH_LBR;
        endcase
        return r;
    endfunction

endpackage

### src/ttc_ctrl.sv
// command sequencer of the text terminal
module ttc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ttc_pkg::dp_sts_t sts,
    output ttc_pkg::dp_cmd_t cmd
);

    ttc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ttc_pkg::ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttc_pkg::ST_INIT:
                if (sts.sweep_last) state_next = ttc_pkg::ST_IDLE;
            ttc_pkg::ST_IDLE:
                if (s_tvalid) state_next = ttc_pkg::ST_EXEC;
            ttc_pkg::ST_EXEC:
            begin
                case (sts.cmd)
                    ttc_pkg::CMD_PUT:
                        if (sts.exec_scroll)
                            state_next = ttc_pkg::ST_SCR_RD;
                        else if (sts.exec_glyph)
                            state_next = ttc_pkg::ST_GLYPH;
                        else
                            state_next = ttc_pkg::ST_DONE;
                    ttc_pkg::CMD_CLEAR:
                        state_next = ttc_pkg::ST_CLR;
                    default:
                        state_next = ttc_pkg::ST_DONE;
                endcase
            end
            ttc_pkg::ST_GLYPH:
                if (sts.glyph_scroll)
                    state_next = ttc_pkg::ST_SCR_RD;
                else if (!sts.glyph_more)
                    state_next = ttc_pkg::ST_DONE;
            ttc_pkg::ST_SCR_RD:
                state_next = ttc_pkg::ST_SCR_WR;
            ttc_pkg::ST_SCR_WR:
                if (!sts.sweep_last)
                    state_next = ttc_pkg::ST_SCR_RD;
                else if (sts.glyph_left)
                    state_next = ttc_pkg::ST_GLYPH;
                else
                    state_next = ttc_pkg::ST_DONE;
            ttc_pkg::ST_CLR:
                if (sts.sweep_last) state_next = ttc_pkg::ST_DONE;
            ttc_pkg::ST_DONE:
                if (sts.out_free) state_next = ttc_pkg::ST_IDLE;
            default:
                state_next = ttc_pkg::ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ttc_pkg::ST_INIT:   cmd.clr = 1'b1;
            ttc_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            ttc_pkg::ST_EXEC:   cmd.exec = 1'b1;
            ttc_pkg::ST_GLYPH:  cmd.glyph = 1'b1;
            ttc_pkg::ST_SCR_RD: cmd.scr_rd = 1'b1;
            ttc_pkg::ST_SCR_WR: cmd.scr_wr = 1'b1;
            ttc_pkg::ST_CLR:    cmd.clr = 1'b1;
            ttc_pkg::ST_DONE:   cmd.load = sts.out_free;
            default:            cmd = '0;
        endcase
    end

endmodule

### src/ttc_dp.sv
// screen store, cursor, escape parser and result register of the text terminal
`include "text_terminal_with_color_escapes_defines.svh"

module ttc_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [23:0]      s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,
    input  ttc_pkg::dp_cmd_t cmd,
    output ttc_pkg::dp_sts_t sts
);

    localparam int AW = ttc_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST_CELL = AW'(ttc_pkg::CELLS - 1);
    localparam logic [AW-1:0] KEEP_CELLS = AW'(ttc_pkg::CELLS - ttc_pkg::COLS);
    localparam logic [ttc_pkg::COL_W-1:0] LAST_COL = ttc_pkg::COL_W'(ttc_pkg::COLS - 1);
    localparam logic [ttc_pkg::ROW_W-1:0] LAST_ROW = ttc_pkg::ROW_W'(ttc_pkg::LINES - 1);

    // latched transaction
    ttc_pkg::cmd_t cmd_reg;
    logic [7:0] ch_reg;
    logic [ttc_pkg::COL_W-1:0] x_reg;
    logic [ttc_pkg::ROW_W-1:0] y_reg;

    logic [ttc_pkg::COL_W-1:0] col_reg, col_next;
    logic [ttc_pkg::ROW_W-1:0] line_reg, line_next;
    logic [7:0] attr_reg, attr_next;
    logic esc_reg, esc_next;
    logic [1:0] pc_reg, pc_next;
    logic [7:0] code_reg, code_next;
    logic [1:0] g_reg, g_next;
    logic [1:0] gcnt_reg, gcnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic out_valid_reg, out_valid_next;
    logic [39:0] out_reg;

    logic [15:0] mem [ttc_pkg::CELLS];
    logic [15:0] mem_q;
    logic we, re;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata;
    logic exec_glyph, exec_scroll;

    logic [7:0] in_ch;
    logic [ttc_pkg::COL_W-1:0] in_col, in_x;
    logic [ttc_pkg::ROW_W-1:0] in_row, in_y;
    logic [AW-1:0] cur_pos, rd_pos;
    logic [7:0] glyph_ch;
    logic is_lead, lead_match, is_digit;
    logic [11:0] code_mul;
    logic [2:0] code_lo;
    logic [7:0] new_attr;
    logic [7:0] cell_ch, cell_at;

    assign in_ch  = s_tdata[9:2];
    assign in_col = s_tdata[16:10];
    assign in_row = s_tdata[21:17];
    assign in_x   = (in_col > LAST_COL) ? LAST_COL : in_col;
    assign in_y   = (in_row > LAST_ROW) ? LAST_ROW : in_row;

    assign cur_pos = AW'(line_reg) * AW'(ttc_pkg::COLS) + AW'(col_reg);
    assign rd_pos  = AW'(y_reg) * AW'(ttc_pkg::COLS) + AW'(x_reg);
    assign glyph_ch = (g_reg == gcnt_reg) ? ch_reg : ttc_pkg::lead_char(g_reg);

    assign is_lead = (ch_reg == ttc_pkg::CH_BSL) || (ch_reg == ttc_pkg::CH_E) ||
                     (ch_reg == ttc_pkg::CH_LBR) || (ch_reg == ttc_pkg::CH_M);
    assign lead_match = (pc_reg != 2'd3) && (ttc_pkg::lead_char(pc_reg) == ch_reg);
    assign is_digit = (ch_reg >= ttc_pkg::CH_ZERO) && (ch_reg <= ttc_pkg::CH_NINE);
    assign code_mul = 12'(code_reg) * 12'd10 + 12'(ch_reg - ttc_pkg::CH_ZERO);
    assign code_lo = code_reg[2:0];

    // sgr code applied to the current attribute
    always_comb
    begin
        new_attr = attr_reg;
        if (code_reg >= 8'd40 && code_reg <= 8'd47)
            new_attr = (attr_reg & ttc_pkg::MASK_FG_KEEP) |
                       {1'b0, ttc_pkg::iso_to_vga(code_lo), 4'b0};
        else if (code_reg >= 8'd30 && code_reg <= 8'd37)
            new_attr = (attr_reg & ttc_pkg::MASK_BG_KEEP) |
                       {5'b0, ttc_pkg::iso_to_vga(code_lo - 3'd6)};
        else if (code_reg == 8'd0)
            new_attr = ttc_pkg::ATTR_DEFAULT;
        else if (code_reg == 8'd1)
            new_attr = attr_reg | ttc_pkg::BIT_BRIGHT;
        else if (code_reg == 8'd5)
            new_attr = attr_reg | ttc_pkg::BIT_FLASH;
    end

    always_comb
    begin
        col_next       = col_reg;
        line_next      = line_reg;
        attr_next      = attr_reg;
        esc_next       = esc_reg;
        pc_next        = pc_reg;
        code_next      = code_reg;
        g_next         = g_reg;
        gcnt_next      = gcnt_reg;
        idx_next       = idx_reg;
        we             = 1'b0;
        re             = 1'b0;
        waddr          = idx_reg;
        raddr          = rd_pos;
        wdata          = {attr_reg, 8'h00};
        exec_glyph     = 1'b0;
        exec_scroll    = 1'b0;

        if (cmd.exec)
        begin
            g_next    = 2'd3;
            gcnt_next = 2'd0;
            case (cmd_reg)
                ttc_pkg::CMD_PUT:
                begin
                    if (esc_reg)
                    begin
                        if (ch_reg == ttc_pkg::CH_M || ch_reg == ttc_pkg::CH_SEMI)
                        begin
                            attr_next = new_attr;
                            code_next = 8'd0;
                            if (ch_reg == ttc_pkg::CH_M)
                                esc_next = 1'b0;
                        end
                        else if (is_digit)
                            code_next = (code_mul > 12'd255) ? 8'd255 : code_mul[7:0];
                    end
                    else if (ch_reg == ttc_pkg::CH_LF)
                    begin
                        col_next = '0;
                        if (line_reg == LAST_ROW)
                            exec_scroll = 1'b1;
                        else
                            line_next = line_reg + ttc_pkg::ROW_W'(1);
                    end
                    else if (ch_reg == ttc_pkg::CH_CR)
                        col_next = '0;
                    else if (is_lead && lead_match)
                    begin
                        if (pc_reg == 2'd2)
                        begin
                            pc_next   = 2'd0;
                            esc_next  = 1'b1;
                            code_next = 8'd0;
                        end
                        else
                            pc_next = pc_reg + 2'd1;
                    end
                    else
                    begin
                        // plain glyph; a lead char that breaks the prefix replays the matched characters first
                        exec_glyph = 1'b1;
                        g_next    = 2'd0;
                        gcnt_next = is_lead ? pc_reg : 2'd0;
                        if (is_lead)
                        begin
                            pc_next  = 2'd0;
                            esc_next = 1'b0;
                        end
                    end
                end
                ttc_pkg::CMD_MOVE:
                begin
                    col_next  = x_reg;
                    line_next = y_reg;
                end
                ttc_pkg::CMD_CLEAR:
                begin
                    col_next  = '0;
                    line_next = '0;
                end
                default:
                    re = 1'b1;
            endcase
        end

        if (cmd.glyph)
        begin
            we     = 1'b1;
            waddr  = cur_pos;
            wdata  = {attr_reg, glyph_ch};
            g_next = g_reg + 2'd1;
            if (col_reg == LAST_COL)
            begin
                col_next = '0;
                if (line_reg != LAST_ROW)
                    line_next = line_reg + ttc_pkg::ROW_W'(1);
            end
            else
                col_next = col_reg + ttc_pkg::COL_W'(1);
        end

        if (cmd.scr_rd)
        begin
            re    = 1'b1;
            raddr = (idx_reg < KEEP_CELLS) ? idx_reg + AW'(ttc_pkg::COLS) : idx_reg;
        end

        if (cmd.scr_wr)
        begin
            we    = 1'b1;
            wdata = (idx_reg < KEEP_CELLS) ? mem_q : {mem_q[15:8], 8'h00};
        end

        if (cmd.clr)
            we = 1'b1;

        if (cmd.scr_wr || cmd.clr)
            idx_next = (idx_reg == LAST_CELL) ? '0 : idx_reg + AW'(1);
    end

    assign sts.exec_glyph   = exec_glyph;
    assign sts.exec_scroll  = exec_scroll;
    assign sts.cmd          = cmd_reg;
    assign sts.glyph_more   = (g_reg != gcnt_reg);
    assign sts.glyph_scroll = (col_reg == LAST_COL) && (line_reg == LAST_ROW);
    assign sts.glyph_left   = (g_reg <= gcnt_reg);
    assign sts.sweep_last   = (idx_reg == LAST_CELL);
    assign sts.out_free     = !out_valid_reg || m_tready;

    assign out_valid_next = cmd.load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            line_reg      <= '0;
            attr_reg      <= ttc_pkg::ATTR_DEFAULT;
            esc_reg       <= 1'b0;
            pc_reg        <= 2'd0;
            code_reg      <= 8'd0;
            g_reg         <= 2'd3;
            gcnt_reg      <= 2'd0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            line_reg      <= line_next;
            attr_reg      <= attr_next;
            esc_reg       <= esc_next;
            pc_reg        <= pc_next;
            code_reg      <= code_next;
            g_reg         <= g_next;
            gcnt_reg      <= gcnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg <= ttc_pkg::cmd_t'(s_tdata[1:0]);
            ch_reg  <= in_ch;
            x_reg   <= in_x;
            y_reg   <= in_y;
        end
        if (cmd.load)
            out_reg <= {3'b0, esc_reg, cell_at, cell_ch, attr_reg, line_reg, col_reg};
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            mem_q <= mem[raddr];
    end

    assign cell_ch = (cmd_reg == ttc_pkg::CMD_READ) ? mem_q[7:0] : 8'h00;
    assign cell_at = (cmd_reg == ttc_pkg::CMD_READ) ? mem_q[15:8] : 8'h00;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `TTC_ASSERT(a_col_range, col_reg <= LAST_COL)
    `TTC_ASSERT(a_row_range, line_reg <= LAST_ROW)
    `TTC_ASSERT(a_esc_no_prefix, !(esc_reg && pc_reg != 2'd0))
    `TTC_ASSERT_NEXT(a_glyph_writes, cmd.glyph, g_reg != 2'd0)

endmodule

### src/text_terminal_with_color_escapes.sv
// Text-mode terminal with ansi color escapes: top level.
// Input stream s_*: one command per transaction (put char, move cursor,
// clear screen, read cell). Output stream m_*: one result per command with
// cursor position, current attribute, read cell and escape flag.
// After reset the screen store (80 x 25 cells, one write and one read port)
// is swept to blank gray-on-black, one cell a cycle, with s_tready low.
// Then s_tready is high whenever the sequencer is idle.
// A put of a failed escape prefix first replays the matched prefix characters;
// clear sweeps every cell; a put that scrolls shifts the screen up one line,
// reading then writing each cell through the single memory port pair.
// One command is in work at a time; the result register lets the next
// command be taken while the last result waits. When the receiver stalls
// with m_tready low, the finished result holds and the block stops before
// loading the next one.
module text_terminal_with_color_escapes (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command[1:0], char_code[9:2], col[16:10], row[21:17]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // cursor_col[6:0], cursor_row[11:7], current_attr[19:12],
                                   // cell_char[27:20], cell_attr[35:28], in_escape[36]
);

    ttc_pkg::dp_cmd_t cmd;
    ttc_pkg::dp_sts_t sts;

    ttc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

### tb/tb.sv
// self-checking testbench of the text terminal with color escapes
module tb;

    // first member lands in the highest bits
    typedef struct packed {
        logic       esc;
        logic [7:0] rd_attr;
        logic [7:0] rd_char;
        logic [7:0] attr;
        logic [4:0] cur_row;
        logic [6:0] cur_col;
    } term_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    text_terminal_with_color_escapes dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [15:0] scr [ttc_pkg::CELLS];
    int          p_col, p_row;
    logic [7:0]  p_attr;
    logic        p_esc;
    int          p_pfx;
    logic [7:0]  p_code;

    logic [23:0] cmd_q [$];
    term_out_t   exp_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          hold = 0;
    int          s_gap = 0, m_gap = 0;

    function automatic logic [2:0] color_map(input logic [2:0] c);
        logic [2:0] r;
        r = {c[0], c[1], c[2]};
        return r;
    endfunction

    task automatic scroll_screen();
        for (int i = 0; i < ttc_pkg::CELLS - ttc_pkg::COLS; i++)
            scr[i] = scr[i + ttc_pkg::COLS];
        for (int i = ttc_pkg::CELLS - ttc_pkg::COLS; i < ttc_pkg::CELLS; i++)
            scr[i] = {scr[i][15:8], 8'h00};
    endtask

    task automatic glyph(input logic [7:0] c);
        scr[p_col + p_row * ttc_pkg::COLS] = {p_attr, c};
        p_col++;
        if (p_col >= ttc_pkg::COLS)
        begin
            p_col = 0;
            p_row++;
        end
        if (p_row >= ttc_pkg::LINES)
        begin
            scroll_screen();
            p_row = ttc_pkg::LINES - 1;
        end
    endtask

    task automatic sgr_code(input logic [7:0] c);
        if (c >= 40 && c <= 47)
            p_attr = (p_attr & ttc_pkg::MASK_FG_KEEP) | {1'b0, color_map(3'(c - 40)), 4'h0};
        if (c >= 30 && c <= 37)
            p_attr = (p_attr & ttc_pkg::MASK_BG_KEEP) | {5'h0, color_map(3'(c - 30))};
        if (c == 0)
            p_attr = ttc_pkg::ATTR_DEFAULT;
        if (c == 1)
            p_attr = p_attr | ttc_pkg::BIT_BRIGHT;
        if (c == 5)
            p_attr = p_attr | ttc_pkg::BIT_FLASH;
    endtask

    function automatic logic [7:0] prefix_char(input int i);
        return (i == 0) ? ttc_pkg::CH_BSL : (i == 1) ? ttc_pkg::CH_E : ttc_pkg::CH_LBR;
    endfunction

    task automatic put_char(input logic [7:0] c);
        int v;
        if (p_esc)
        begin
            if (c == ttc_pkg::CH_M || c == ttc_pkg::CH_SEMI)
            begin
                sgr_code(p_code);
                p_code = 0;
                if (c == ttc_pkg::CH_M)
                    p_esc = 0;
            end
            else if (c >= ttc_pkg::CH_ZERO && c <= ttc_pkg::CH_NINE)
            begin
                v = p_code * 10 + (c - ttc_pkg::CH_ZERO);
                p_code = (v > 255) ? 8'd255 : 8'(v);
            end
        end
        else if (c == ttc_pkg::CH_LF)
        begin
            p_col = 0;
            p_row++;
            if (p_row >= ttc_pkg::LINES)
            begin
                scroll_screen();
                p_row = ttc_pkg::LINES - 1;
            end
        end
        else if (c == ttc_pkg::CH_CR)
            p_col = 0;
        else if (c == ttc_pkg::CH_BSL || c == ttc_pkg::CH_E ||
                 c == ttc_pkg::CH_LBR || c == ttc_pkg::CH_M)
        begin
            if (p_pfx < 3 && prefix_char(p_pfx) == c)
            begin
                p_pfx++;
                if (p_pfx >= 3)
                begin
                    p_pfx = 0;
                    p_esc = 1;
                    p_code = 0;
                end
            end
            else
            begin
                for (int i = 0; i < p_pfx; i++)
                    glyph(prefix_char(i));
                glyph(c);
                p_pfx = 0;
            end
        end
        else
            glyph(c);
    endtask

    task automatic predict_term(input logic [23:0] d);
        term_out_t r;
        int x, y;
        ttc_pkg::cmd_t cmd;
        cmd = ttc_pkg::cmd_t'(d[1:0]);
        x = d[16:10];
        y = d[21:17];
        if (x > ttc_pkg::COLS - 1) x = ttc_pkg::COLS - 1;
        if (y > ttc_pkg::LINES - 1) y = ttc_pkg::LINES - 1;
        r.rd_char = 0;
        r.rd_attr = 0;
        case (cmd)
            ttc_pkg::CMD_PUT: put_char(d[9:2]);
            ttc_pkg::CMD_MOVE:
            begin
                p_col = x;
                p_row = y;
            end
            ttc_pkg::CMD_CLEAR:
            begin
                p_col = 0;
                p_row = 0;
                for (int i = 0; i < ttc_pkg::CELLS; i++)
                    scr[i] = {p_attr, 8'h00};
            end
            default:
            begin
                r.rd_char = scr[x + y * ttc_pkg::COLS][7:0];
                r.rd_attr = scr[x + y * ttc_pkg::COLS][15:8];
            end
        endcase
        r.cur_col = 7'(p_col);
        r.cur_row = 5'(p_row);
        r.attr = p_attr;
        r.esc = p_esc;
        exp_q.push_back(r);
    endtask

    function automatic logic [23:0] mk(input ttc_pkg::cmd_t c, input logic [7:0] ch,
                                       input logic [6:0] x, input logic [4:0] y);
        return {2'b00, y, x, ch, c};
    endfunction

    task automatic push_put(input logic [7:0] ch);
        cmd_q.push_back(mk(ttc_pkg::CMD_PUT, ch, 7'($urandom), 5'($urandom)));
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            push_put(s[i]);
    endtask

    // driver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_term(s_tdata);
                s_gap <= $urandom_range(0, 4);
                if (s_gap == 0 && !hold && cmd_q.size() > 0)
                    s_tdata <= cmd_q.pop_front();
                else
                    s_tvalid <= 1'b0;
            end
            else if (!s_tvalid)
            begin
                if (s_gap > 0)
                    s_gap <= s_gap - 1;
                else if (!hold && cmd_q.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= cmd_q.pop_front();
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        term_out_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = term_out_t'(m_tdata[36:0]);
                if (exp_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", m_tdata);
                end
                else
                begin
                    want = exp_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp col %0d row %0d attr %h ch %h ca %h esc %b,",
                                      " got col %0d row %0d attr %h ch %h ca %h esc %b"},
                                want.cur_col, want.cur_row, want.attr, want.rd_char,
                                want.rd_attr, want.esc, got.cur_col, got.cur_row,
                                got.attr, got.rd_char, got.rd_attr, got.esc);
                    end
                end
            end
            if (m_gap > 0)
            begin
                m_tready <= 1'b0;
                m_gap <= m_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    m_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (cycles > 30000000)
        begin
            $display("text_terminal_with_color_escapes verification failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        for (int i = 0; i < ttc_pkg::CELLS; i++)
            scr[i] = {ttc_pkg::ATTR_DEFAULT, 8'h00};
        p_col = 0; p_row = 0; p_attr = ttc_pkg::ATTR_DEFAULT;
        p_esc = 0; p_pfx = 0; p_code = 0;

        // directed: extremes, clamping, escapes, failed prefix
        cmd_q.push_back(mk(ttc_pkg::CMD_READ, 8'hFF, 7'h7F, 5'h1F));
        cmd_q.push_back(mk(ttc_pkg::CMD_MOVE, 8'h00, 7'h7F, 5'h1F));
        push_put(8'hFF);
        cmd_q.push_back(mk(ttc_pkg::CMD_READ, 8'h00, 7'd79, 5'd24));
        push_str("\\e[1;31;42;5m");
        push_put(8'h41);
        push_str("\\e[m");
        push_str("\\e[999x;0m");
        push_str("\\ex\\e\\m");
        push_put(ttc_pkg::CH_CR);
        push_put(ttc_pkg::CH_LF);
        cmd_q.push_back(mk(ttc_pkg::CMD_CLEAR, 8'h00, 7'h00, 5'h00));
        cmd_q.push_back(mk(ttc_pkg::CMD_READ, 8'h00, 7'd0, 5'd0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (cmd_q.size() == 0 && exp_q.size() == 0 && !s_tvalid);

        // pause the driver after the block has drained
        hold = 1;
        repeat (10) @(posedge clk);
        hold = 0;

        for (int n = 0; n < 680; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                push_put(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(32, 126)));
            else if (r < 65)
            begin
                push_str("\\e[");
                push_str($sformatf("%0d;%0d", $urandom_range(0, 49), $urandom_range(0, 300)));
                push_put(ttc_pkg::CH_M);
            end
            else if (r < 70)
                push_put(($urandom_range(0, 1) == 0) ? ttc_pkg::CH_LF : ttc_pkg::CH_CR);
            else if (r < 75)
                push_put(prefix_char($urandom_range(0, 2)));
            else if (r < 85)
                cmd_q.push_back(mk(ttc_pkg::CMD_MOVE, 8'($urandom), 7'($urandom),
                                   5'($urandom)));
            else if (r < 99)
                cmd_q.push_back(mk(ttc_pkg::CMD_READ, 8'($urandom),
                    ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 79)),
                    ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(20, 24))));
            else if (n < 620 && $urandom_range(0, 3) == 0)
                cmd_q.push_back(mk(ttc_pkg::CMD_CLEAR, 8'($urandom), 7'($urandom),
                                   5'($urandom)));
            else
                push_put(ttc_pkg::CH_LF);
        end
        wait (cmd_q.size() == 0 && !s_tvalid);
        wait (exp_q.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0 && exp_q.size() == 0)
            $display("text_terminal_with_color_escapes verification clean");
        else
            $display("text_terminal_with_color_escapes verification failed");
        $finish;
    end
endmodule

### sim.f
+incdir+src
src/ttc_pkg.sv
src/ttc_ctrl.sv
src/ttc_dp.sv
src/text_terminal_with_color_escapes.sv
tb/tb.sv
